// ----- src/phs_pkg.sv -----
`default_nettype none
package phs_pkg;

    localparam int NUM_W = 20;
    localparam int DEN_W = 11;
    localparam int QUO_W = 10;
    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES = 7;
    localparam int DEPTH = FRONT_STAGES + QUO_W + BACK_STAGES;

    localparam logic [2:0] MODE_HUE_BOTH    = 3'd0;
    localparam logic [2:0] MODE_HUE_POS     = 3'd1;
    localparam logic [2:0] MODE_HUE_NEG     = 3'd2;
    localparam logic [2:0] MODE_RGB_NOSHINY = 3'd3;
    localparam logic [2:0] MODE_RGB_SHINY   = 3'd4;
    localparam logic [2:0] MODE_RGB_ALWAYS  = 3'd5;

    localparam logic [1:0] REG_LIMIT_MODE = 2'd0;
    localparam logic [1:0] REG_COLORATION = 2'd1;
    localparam logic [1:0] REG_SHINY      = 2'd2;

    // floor(x / 1000) as (x * RECIP_1000) >> 32 for x below 2^21
    localparam logic [22:0] RECIP_1000 = 23'd4294968;
    // c * 31 / 1000 as (c * TO5_MUL) >> 32
    localparam logic [27:0] TO5_MUL = 28'd133144008;

    typedef struct packed {
        logic [8:0]  palette_index;
        logic [14:0] color_in;
    } t_in;

    typedef struct packed {
        logic [8:0]  palette_index_out;
        logic [14:0] color_out;
    } t_out;

    typedef struct packed {
        logic [8:0]        index;
        logic              is_rgb;
        logic [14:0]       rgb;
        logic signed [8:0] shift;
        logic              hneg;
        logic [12:0]       hoff;
    } t_side;

    // c * 1000 / 31 for a 5-bit channel
    function automatic logic [9:0] phs_scale(input logic [4:0] c);
        logic [30:0] prod;
        begin
            prod = 31'(c) * 31'd33826000;
            return prod[29:20];
        end
    endfunction

    // base-5 digits of the value: {red, green, blue}
    function automatic logic [8:0] phs_digits(input logic [6:0] val);
        logic [2:0] q25;
        logic [6:0] rem;
        logic [2:0] dr;
        logic [2:0] dg;
        logic [6:0] db;
        begin
            if (val >= 7'd125)      q25 = 3'd5;
            else if (val >= 7'd100) q25 = 3'd4;
            else if (val >= 7'd75)  q25 = 3'd3;
            else if (val >= 7'd50)  q25 = 3'd2;
            else if (val >= 7'd25)  q25 = 3'd1;
            else                    q25 = 3'd0;
            rem = val - 7'(q25 * 7'd25);
            dr = (q25 == 3'd5) ? 3'd0 : q25;
            if (rem >= 7'd20)      dg = 3'd4;
            else if (rem >= 7'd15) dg = 3'd3;
            else if (rem >= 7'd10) dg = 3'd2;
            else if (rem >= 7'd5)  dg = 3'd1;
            else                   dg = 3'd0;
            db = rem - 7'(dg * 7'd5);
            return {dr, dg, db[2:0]};
        end
    endfunction

    function automatic logic [4:0] phs_adjust(input logic [4:0] c, input logic [2:0] d);
        logic signed [6:0] v;
        begin
            v = signed'(7'(c)) + signed'(7'(d)) - 7'sd2;
            if (v > 7'sd31) v = 7'sd31 - signed'(7'(d >> 1));
            if (v < 7'sd0) v = signed'(7'(d >> 1));
            return v[4:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/palette_hue_shift_hsl.sv -----
// Palette recolor unit: takes one RGB555 palette word per cycle with its palette index and
// returns the recolored word with the same index, in order, through front, divider and back
// stages. Every cycle a new word may enter; the whole pipeline holds while the output word
// waits. The path is set by limit_mode and shiny: per-channel offsets from base-5 digits
// of coloration_value, or a hue rotation through integer HSL, whose two divisions run in
// 10-stage bit-per-stage dividers. Write configuration only while the pipeline is empty.
`default_nettype none
module palette_hue_shift_hsl import phs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);

    logic [2:0]       r_mode;
    logic [6:0]       r_val;
    logic             r_shiny;
    logic [DEPTH-1:0] r_v;
    logic             en;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_v[DEPTH-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_v[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_val   <= '0;
            r_shiny <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LIMIT_MODE: r_mode  <= i_cfg_data[2:0];
                REG_COLORATION: r_val   <= i_cfg_data;
                REG_SHINY:      r_shiny <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[DEPTH-2:0], i_in_valid};
        end
    end

    logic [NUM_W-1:0] num_s, num_h;
    logic [DEN_W-1:0] den_s, den_h;
    logic [QUO_W-1:0] qs, qh;
    t_side            side_f, side_d;
    logic [9:0]       l_f, l_d;

    phs_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_in    (i_in_data),
        .i_mode  (r_mode),
        .i_val   (r_val),
        .i_shiny (r_shiny),
        .o_num_s (num_s),
        .o_den_s (den_s),
        .o_num_h (num_h),
        .o_den_h (den_h),
        .o_side  (side_f),
        .o_l     (l_f)
    );

    phs_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .SW(10)) u_div_s (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_s),
        .i_den  (den_s),
        .i_side (l_f),
        .o_quo  (qs),
        .o_side (l_d)
    );

    phs_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .SW($bits(t_side))) u_div_h (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_h),
        .i_den  (den_h),
        .i_side (side_f),
        .o_quo  (qh),
        .o_side (side_d)
    );

    phs_back u_back (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_qs   (qs),
        .i_qh   (qh),
        .i_side (side_d),
        .i_l    (l_d),
        .o_out  (o_out_data)
    );

endmodule
`default_nettype wire

// ----- src/phs_front.sv -----
`default_nettype none
module phs_front import phs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire t_in                i_in,
    input  wire logic [2:0]         i_mode,
    input  wire logic [6:0]         i_val,
    input  wire logic               i_shiny,
    output logic      [NUM_W-1:0]   o_num_s,
    output logic      [DEN_W-1:0]   o_den_s,
    output logic      [NUM_W-1:0]   o_num_h,
    output logic      [DEN_W-1:0]   o_den_h,
    output t_side                   o_side,
    output logic      [9:0]         o_l
);

    logic [2:0]        mode_e;
    logic              is_rgb;
    logic signed [8:0] shift;
    logic [8:0]        dig;
    t_side             n_a_side;

    logic [9:0] r_a_r, r_a_g, r_a_b;
    t_side      r_a_side;

    always_comb begin
        mode_e = (i_mode > MODE_RGB_ALWAYS) ? MODE_HUE_BOTH : i_mode;
        is_rgb = (mode_e == MODE_RGB_ALWAYS) || (mode_e == MODE_RGB_NOSHINY && !i_shiny) ||
                 (mode_e == MODE_RGB_SHINY && i_shiny);
        if (mode_e == MODE_HUE_POS)
            shift = signed'({2'b00, i_val});
        else
            shift = signed'({2'b00, i_val}) - (i_shiny ? 9'sd30 : 9'sd40);
        dig = phs_digits(i_val);
        n_a_side.index  = i_in.palette_index;
        n_a_side.is_rgb = is_rgb;
        n_a_side.rgb    = {phs_adjust(i_in.color_in[14:10], dig[2:0]),
                           phs_adjust(i_in.color_in[9:5], dig[5:3]),
                           phs_adjust(i_in.color_in[4:0], dig[8:6])};
        n_a_side.shift  = shift;
        n_a_side.hneg   = 1'b0;
        n_a_side.hoff   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_r    <= phs_scale(i_in.color_in[4:0]);
            r_a_g    <= phs_scale(i_in.color_in[9:5]);
            r_a_b    <= phs_scale(i_in.color_in[14:10]);
            r_a_side <= n_a_side;
        end
    end

    logic [9:0]         mx, mn, d, mag, l;
    logic [10:0]        sum;
    logic signed [10:0] diff;
    logic [12:0]        off;
    logic [NUM_W-1:0]   n_num_s, n_num_h;
    logic [DEN_W-1:0]   n_den_s, n_den_h;
    t_side              n_b_side;

    always_comb begin
        mx = (r_a_r > r_a_g) ? r_a_r : r_a_g;
        mn = (r_a_r < r_a_g) ? r_a_r : r_a_g;
        if (r_a_b > mx) mx = r_a_b;
        if (r_a_b < mn) mn = r_a_b;
        d   = mx - mn;
        sum = 11'(mx) + 11'(mn);
        l   = sum[10:1];
        if (mx == r_a_r) begin
            diff = signed'(11'(r_a_g)) - signed'(11'(r_a_b));
            off  = (r_a_g < r_a_b) ? 13'd6000 : 13'd0;
        end else if (mx == r_a_g) begin
            diff = signed'(11'(r_a_b)) - signed'(11'(r_a_r));
            off  = 13'd2000;
        end else begin
            diff = signed'(11'(r_a_r)) - signed'(11'(r_a_g));
            off  = 13'd4000;
        end
        mag = (diff < 0) ? 10'(-diff) : 10'(diff);
        if (d == 10'd0) begin
            n_num_s = '0;
            n_den_s = DEN_W'(1);
            n_num_h = '0;
            n_den_h = DEN_W'(1);
            off     = '0;
        end else begin
            n_num_s = NUM_W'(d) * NUM_W'(1000);
            n_den_s = (l > 10'd500) ? DEN_W'(11'd2000 - sum) : DEN_W'(sum);
            n_num_h = NUM_W'(mag) * NUM_W'(1000);
            n_den_h = DEN_W'(d);
        end
        n_b_side      = r_a_side;
        n_b_side.hneg = (diff < 0) && (d != 10'd0);
        n_b_side.hoff = off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num_s <= n_num_s;
            o_den_s <= n_den_s;
            o_num_h <= n_num_h;
            o_den_h <= n_den_h;
            o_side  <= n_b_side;
            o_l     <= l;
        end
    end

endmodule
`default_nettype wire

// ----- src/phs_div.sv -----
`default_nettype none
module phs_div import phs_pkg::*; #(
    parameter int NW = NUM_W,
    parameter int DW = DEN_W,
    parameter int QW = QUO_W,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic      [QW-1:0] o_quo,
    output logic      [SW-1:0] o_side
);

    localparam int XW = DW + QW;
    localparam int CW = (NW > XW) ? NW : XW;

    logic [NW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in;
        logic [CW-1:0] sub;
        logic          ge;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            sub   = CW'(den_in) << (QW - 1 - k);
            ge    = CW'(rem_in) >= sub;
            n_quo = quo_in;
            n_quo[QW-1-k] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? NW'(CW'(rem_in) - sub) : rem_in;
                r_den[k]  <= den_in;
                r_quo[k]  <= n_quo;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule
`default_nettype wire

// ----- src/phs_back.sv -----
`default_nettype none
module phs_back import phs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [QUO_W-1:0]  i_qs,
    input  wire logic [QUO_W-1:0]  i_qh,
    input  wire t_side             i_side,
    input  wire logic [9:0]        i_l,
    output t_out                   o_out
);

    localparam logic [1:0] KIND_UP   = 2'd0;
    localparam logic [1:0] KIND_TOP  = 2'd1;
    localparam logic [1:0] KIND_DOWN = 2'd2;
    localparam logic [1:0] KIND_LOW  = 2'd3;

    // pass-through: index, path select, adjusted color
    logic [24:0] r_pass [BACK_STAGES-1];
    logic [9:0]  r_l    [BACK_STAGES-1];
    logic [9:0]  r_s    [BACK_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass[0] <= {i_side.index, i_side.is_rgb, i_side.rgb};
            r_l[0]    <= i_l;
            r_s[0]    <= i_qs;
            for (int i = 1; i < BACK_STAGES - 1; i++) begin
                r_pass[i] <= r_pass[i-1];
                r_l[i]    <= r_l[i-1];
                r_s[i]    <= r_s[i-1];
            end
        end
    end

    // stage 1
    logic [12:0]       hraw;
    logic [26:0]       r_hm;
    logic [19:0]       r_ls;
    logic [20:0]       r_ls1;
    logic signed [8:0] r_shift;

    always_comb begin
        hraw = i_side.hneg ? i_side.hoff - 13'(i_qh) : i_side.hoff + 13'(i_qh);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hm    <= 27'(hraw) * 27'd10923;
            r_ls    <= 20'(i_l) * 20'(i_qs);
            r_ls1   <= 21'(i_l) * (21'(i_qs) + 21'd1000);
            r_shift <= i_side.shift;
        end
    end

    // stage 2
    logic [11:0] hh;
    logic [9:0]  hw;
    logic [20:0] pnum;
    logic [9:0]  r_h;
    logic [43:0] r_pm;

    always_comb begin
        hh = 12'(r_hm[25:16]) + 12'd1000 + 12'(r_shift);
        if (hh >= 12'd2000)      hw = 10'(hh - 12'd2000);
        else if (hh >= 12'd1000) hw = 10'(hh - 12'd1000);
        else                     hw = 10'(hh);
        pnum = (r_l[0] < 10'd500) ? r_ls1 : 21'(r_ls);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h  <= hw;
            r_pm <= 44'(pnum) * 44'(RECIP_1000);
        end
    end

    // stage 3
    logic [9:0]  t;
    logic [10:0] p, q, tr, tb;
    logic [10:0] r_p, r_q;
    logic [9:0]  r_o [3];

    always_comb begin
        t  = r_pm[41:32];
        p  = (r_l[1] < 10'd500) ? 11'(t) : 11'(r_l[1]) + 11'(r_s[1]) - 11'(t);
        q  = {r_l[1], 1'b0} - p;
        tr = 11'(r_h) + 11'd333;
        tb = 11'(r_h) + 11'd667;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= p;
            r_q    <= q;
            r_o[0] <= (tr >= 11'd1000) ? 10'(tr - 11'd1000) : 10'(tr);
            r_o[1] <= r_h;
            r_o[2] <= (tb >= 11'd1000) ? 10'(tb - 11'd1000) : 10'(tb);
        end
    end

    // stage 4
    logic [1:0]  kind [3];
    logic [10:0] f    [3];
    logic [10:0] dpq;
    logic [21:0] r_prod [3];
    logic [1:0]  r_kind [3];
    logic [10:0] r_p4, r_q4;

    always_comb begin
        dpq = r_p - r_q;
        for (int c = 0; c < 3; c++) begin
            if (r_o[c] < 10'd167) begin
                kind[c] = KIND_UP;
                f[c]    = 11'(r_o[c]) * 11'd6;
            end else if (r_o[c] < 10'd500) begin
                kind[c] = KIND_TOP;
                f[c]    = '0;
            end else if (r_o[c] < 10'd667) begin
                kind[c] = KIND_DOWN;
                f[c]    = (11'd667 - 11'(r_o[c])) * 11'd6;
            end else begin
                kind[c] = KIND_LOW;
                f[c]    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= 22'(dpq) * 22'(f[c]);
                r_kind[c] <= kind[c];
            end
            r_p4 <= r_p;
            r_q4 <= r_q;
        end
    end

    // stage 5
    logic [44:0] r_x    [3];
    logic [1:0]  r_kind5 [3];
    logic [10:0] r_p5, r_q5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_x[c]     <= 45'(r_prod[c]) * 45'(RECIP_1000);
                r_kind5[c] <= r_kind[c];
            end
            r_p5 <= r_p4;
            r_q5 <= r_q4;
        end
    end

    // stage 6
    logic [10:0] ch [3];
    logic [38:0] r_y [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r_kind5[c])
                KIND_UP:   ch[c] = r_q5 + r_x[c][42:32];
                KIND_DOWN: ch[c] = r_q5 + r_x[c][42:32];
                KIND_TOP:  ch[c] = r_p5;
                default:   ch[c] = r_q5;
            endcase
            if (r_s[4] == 10'd0) ch[c] = 11'(r_l[4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_y[c] <= 39'(ch[c]) * 39'(TO5_MUL);
            end
        end
    end

    // stage 7: output word
    t_out n_out;

    always_comb begin
        n_out.palette_index_out = r_pass[BACK_STAGES-2][24:16];
        if (r_pass[BACK_STAGES-2][15])
            n_out.color_out = r_pass[BACK_STAGES-2][14:0];
        else
            n_out.color_out = {r_y[2][36:32], r_y[1][36:32], r_y[0][36:32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_out <= n_out;
        end
    end

endmodule
`default_nettype wire
